[rtl/cpa_pkg.sv]
`timescale 1ns / 1ps
package cpa_pkg;

  localparam int COORD_W = 16;
  localparam int CNT_W   = $clog2(COORD_W);

  typedef logic [COORD_W-1:0] coord_t;

  // configuration register indexes
  localparam logic REG_PRIME   = 1'b0;
  localparam logic REG_CURVE_A = 1'b1;

  localparam coord_t PRIME_RESET   = COORD_W'(23);
  localparam coord_t CURVE_A_RESET = COORD_W'(1);
  localparam coord_t PRIME_MIN     = COORD_W'(2);

  typedef struct packed {
    coord_t first_x;
    coord_t first_y;
    coord_t second_x;
    coord_t second_y;
  } in_item_t;

  typedef struct packed {
    coord_t sum_x;
    coord_t sum_y;
    logic   at_infinity;
  } out_item_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
    coord_t  a;
    coord_t  b;
  } alu_req_t;

  typedef struct packed {
    logic   busy;
    logic   done;
    coord_t acc;
    coord_t quo;
  } alu_resp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RED_X1,
    ST_RED_Y1,
    ST_RED_X2,
    ST_RED_Y2,
    ST_RED_A,
    ST_CMP,
    ST_DBL_SQ,
    ST_DBL_2,
    ST_DBL_3,
    ST_DBL_A,
    ST_DBL_DEN,
    ST_CH_DY,
    ST_CH_DX,
    ST_EU_CHK,
    ST_EU_DIV,
    ST_EU_MUL,
    ST_EU_SUB,
    ST_SLOPE,
    ST_X3_SQ,
    ST_X3_S1,
    ST_X3_S2,
    ST_Y3_D,
    ST_Y3_M,
    ST_Y3_S,
    ST_DONE
  } state_t;

  // (a + b) mod m for a, b < m
  function automatic coord_t add_mod(coord_t a, coord_t b, coord_t m);
    logic [COORD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[COORD_W-1:0];
  endfunction

  // (a - b) mod m for a, b < m; the wrap of the low bits gives a - b + m
  function automatic coord_t sub_mod(coord_t a, coord_t b, coord_t m);
    coord_t d;
    d = a - b;
    if (a < b) begin
      d = d + m;
    end
    return d;
  endfunction

endpackage

[rtl/cpa_alu.sv]
`timescale 1ns / 1ps
module cpa_alu (
  input  logic               clk,
  input  logic               rst_n,
  input  cpa_pkg::coord_t    modulus,
  input  cpa_pkg::alu_req_t  req,
  output cpa_pkg::alu_resp_t resp
);
  import cpa_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  alu_op_t          op_r, op_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  coord_t           acc_r, acc_nxt;
  coord_t           opa_r, opa_nxt;
  coord_t           opb_r, opb_nxt;

  logic [COORD_W:0] rem_sh;
  logic [COORD_W:0] rem_diff;
  logic             rem_ge;

  // restoring division step: shift in the next dividend bit, subtract if it fits
  assign rem_sh   = {acc_r, opa_r[COORD_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, opb_r};
  assign rem_diff = rem_sh - {1'b0, opb_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    opa_nxt  = opa_r;
    opb_nxt  = opb_r;
    if (req.start) begin
      op_nxt = req.op;
      case (req.op)
        ALU_ADD: begin
          acc_nxt  = add_mod(req.a, req.b, modulus);
          done_nxt = 1'b1;
        end
        ALU_SUB: begin
          acc_nxt  = sub_mod(req.a, req.b, modulus);
          done_nxt = 1'b1;
        end
        default: begin
          acc_nxt  = '0;
          opa_nxt  = req.a;
          opb_nxt  = req.b;
          cnt_nxt  = CNT_W'(COORD_W - 1);
          busy_nxt = 1'b1;
        end
      endcase
    end else if (busy_r) begin
      case (op_r)
        ALU_MUL: begin
          // multiplier LSB first, multiplicand doubles mod m each step
          if (opb_r[0]) begin
            acc_nxt = add_mod(acc_r, opa_r, modulus);
          end
          opa_nxt = add_mod(opa_r, opa_r, modulus);
          opb_nxt = opb_r >> 1;
        end
        default: begin
          acc_nxt = rem_ge ? rem_diff[COORD_W-1:0] : rem_sh[COORD_W-1:0];
          opa_nxt = {opa_r[COORD_W-2:0], rem_ge};
        end
      endcase
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= ALU_ADD;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    opa_r <= opa_nxt;
    opb_r <= opb_nxt;
  end

  assign resp.busy = busy_r;
  assign resp.done = done_r;
  assign resp.acc  = acc_r;
  assign resp.quo  = opa_r;

endmodule

[rtl/curve_point_add_mod_p.sv]
`timescale 1ns / 1ps
// Channel   Ports                          Beat
// input     in_valid, in_stall, in_data     two affine points, one beat per addition
// result    out_valid, out_stall, out_data  sum point or infinity flag
// config    cfg_we, cfg_index, cfg_data     modulus p (index 0), coefficient a (index 1)
//
// One addition at a time through a shared modular unit (add, sub, shift-add multiply,
// restoring divide). Multiply and divide step through all W bits, add and sub do not;
// W = 16. A doubling runs nine multiplies or divides and a chord eight, plus a divide,
// a multiply and a subtract for each Euclid round of the inverse.
// in_stall is high from acceptance until the result is loaded into the output register;
// a waiting result does not block the next beat. rst_n is synchronous; the registers
// reset to p = 23, a = 1.
module curve_point_add_mod_p (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cpa_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cpa_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  cpa_pkg::coord_t    cfg_data
);
  import cpa_pkg::*;

  state_t    state_r, state_nxt;
  logic      wait_r, wait_nxt;
  logic      inf_r, inf_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  coord_t    prime_r, curve_a_r;

  coord_t x1_r, x1_nxt, y1_r, y1_nxt, x2_r, x2_nxt, y2_r, y2_nxt;
  coord_t a_r, a_nxt, num_r, num_nxt, tmp_r, tmp_nxt;
  coord_t r1_r, r1_nxt, r2_r, r2_nxt, t1_r, t1_nxt, t2_r, t2_nxt;
  coord_t q_r, q_nxt, rem_r, rem_nxt, x3_r, x3_nxt, y3_r, y3_nxt;

  alu_req_t  alu_req;
  alu_resp_t alu_resp;
  logic      alu_use;
  logic      alu_cap;
  logic      out_load;
  coord_t    q_mod;

  cpa_alu u_alu (
    .clk     (clk),
    .rst_n   (rst_n),
    .modulus (prime_r),
    .req     (alu_req),
    .resp    (alu_resp)
  );

  // quotient never exceeds p, so q mod p only folds q == p to zero
  assign q_mod    = (q_r == prime_r) ? '0 : q_r;
  assign alu_cap  = wait_r && alu_resp.done;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    wait_nxt  = wait_r;
    inf_nxt   = inf_r;
    x1_nxt    = x1_r;
    y1_nxt    = y1_r;
    x2_nxt    = x2_r;
    y2_nxt    = y2_r;
    a_nxt     = a_r;
    num_nxt   = num_r;
    tmp_nxt   = tmp_r;
    r1_nxt    = r1_r;
    r2_nxt    = r2_r;
    t1_nxt    = t1_r;
    t2_nxt    = t2_r;
    q_nxt     = q_r;
    rem_nxt   = rem_r;
    x3_nxt    = x3_r;
    y3_nxt    = y3_r;
    alu_use   = 1'b0;
    alu_req.start = 1'b0;
    alu_req.op    = ALU_ADD;
    alu_req.a     = '0;
    alu_req.b     = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          x1_nxt  = in_data.first_x;
          y1_nxt  = in_data.first_y;
          x2_nxt  = in_data.second_x;
          y2_nxt  = in_data.second_y;
          inf_nxt = 1'b0;
          if (prime_r < PRIME_MIN) begin
            inf_nxt   = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_RED_X1;
          end
        end
      end
      ST_RED_X1: begin
        alu_use = 1'b1; alu_req.op = ALU_DIV; alu_req.a = x1_r; alu_req.b = prime_r;
        if (alu_cap) begin
          x1_nxt = alu_resp.acc; state_nxt = ST_RED_Y1;
        end
      end
      ST_RED_Y1: begin
        alu_use = 1'b1; alu_req.op = ALU_DIV; alu_req.a = y1_r; alu_req.b = prime_r;
        if (alu_cap) begin
          y1_nxt = alu_resp.acc; state_nxt = ST_RED_X2;
        end
      end
      ST_RED_X2: begin
        alu_use = 1'b1; alu_req.op = ALU_DIV; alu_req.a = x2_r; alu_req.b = prime_r;
        if (alu_cap) begin
          x2_nxt = alu_resp.acc; state_nxt = ST_RED_Y2;
        end
      end
      ST_RED_Y2: begin
        alu_use = 1'b1; alu_req.op = ALU_DIV; alu_req.a = y2_r; alu_req.b = prime_r;
        if (alu_cap) begin
          y2_nxt = alu_resp.acc; state_nxt = ST_RED_A;
        end
      end
      ST_RED_A: begin
        alu_use = 1'b1; alu_req.op = ALU_DIV; alu_req.a = curve_a_r; alu_req.b = prime_r;
        if (alu_cap) begin
          a_nxt = alu_resp.acc; state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (x1_r == x2_r && y1_r == y2_r) begin
          if (y1_r == '0) begin
            inf_nxt   = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_DBL_SQ;
          end
        end else begin
          state_nxt = ST_CH_DY;
        end
      end
      // tangent slope numerator 3*x^2 + a, denominator 2*y
      ST_DBL_SQ: begin
        alu_use = 1'b1; alu_req.op = ALU_MUL; alu_req.a = x1_r; alu_req.b = x1_r;
        if (alu_cap) begin
          tmp_nxt = alu_resp.acc; state_nxt = ST_DBL_2;
        end
      end
      ST_DBL_2: begin
        alu_use = 1'b1; alu_req.op = ALU_ADD; alu_req.a = tmp_r; alu_req.b = tmp_r;
        if (alu_cap) begin
          num_nxt = alu_resp.acc; state_nxt = ST_DBL_3;
        end
      end
      ST_DBL_3: begin
        alu_use = 1'b1; alu_req.op = ALU_ADD; alu_req.a = num_r; alu_req.b = tmp_r;
        if (alu_cap) begin
          num_nxt = alu_resp.acc; state_nxt = ST_DBL_A;
        end
      end
      ST_DBL_A: begin
        alu_use = 1'b1; alu_req.op = ALU_ADD; alu_req.a = num_r; alu_req.b = a_r;
        if (alu_cap) begin
          num_nxt = alu_resp.acc; state_nxt = ST_DBL_DEN;
        end
      end
      ST_DBL_DEN: begin
        alu_use = 1'b1; alu_req.op = ALU_ADD; alu_req.a = y1_r; alu_req.b = y1_r;
        if (alu_cap) begin
          r1_nxt = prime_r; r2_nxt = alu_resp.acc;
          t1_nxt = '0;      t2_nxt = COORD_W'(1);
          state_nxt = ST_EU_CHK;
        end
      end
      ST_CH_DY: begin
        alu_use = 1'b1; alu_req.op = ALU_SUB; alu_req.a = y2_r; alu_req.b = y1_r;
        if (alu_cap) begin
          num_nxt = alu_resp.acc; state_nxt = ST_CH_DX;
        end
      end
      ST_CH_DX: begin
        alu_use = 1'b1; alu_req.op = ALU_SUB; alu_req.a = x2_r; alu_req.b = x1_r;
        if (alu_cap) begin
          // same x, different y: opposite points
          if (alu_resp.acc == '0) begin
            inf_nxt   = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            r1_nxt = prime_r; r2_nxt = alu_resp.acc;
            t1_nxt = '0;      t2_nxt = COORD_W'(1);
            state_nxt = ST_EU_CHK;
          end
        end
      end
      // extended Euclid, coefficients kept mod p; t1 is the inverse once r2 hits zero
      ST_EU_CHK: begin
        state_nxt = (r2_r == '0) ? ST_SLOPE : ST_EU_DIV;
      end
      ST_EU_DIV: begin
        alu_use = 1'b1; alu_req.op = ALU_DIV; alu_req.a = r1_r; alu_req.b = r2_r;
        if (alu_cap) begin
          q_nxt = alu_resp.quo; rem_nxt = alu_resp.acc; state_nxt = ST_EU_MUL;
        end
      end
      ST_EU_MUL: begin
        alu_use = 1'b1; alu_req.op = ALU_MUL; alu_req.a = q_mod; alu_req.b = t2_r;
        if (alu_cap) begin
          q_nxt = alu_resp.acc; state_nxt = ST_EU_SUB;
        end
      end
      ST_EU_SUB: begin
        alu_use = 1'b1; alu_req.op = ALU_SUB; alu_req.a = t1_r; alu_req.b = q_r;
        if (alu_cap) begin
          t1_nxt = t2_r;  t2_nxt = alu_resp.acc;
          r1_nxt = r2_r;  r2_nxt = rem_r;
          state_nxt = ST_EU_CHK;
        end
      end
      ST_SLOPE: begin
        alu_use = 1'b1; alu_req.op = ALU_MUL; alu_req.a = num_r; alu_req.b = t1_r;
        if (alu_cap) begin
          tmp_nxt = alu_resp.acc; state_nxt = ST_X3_SQ;
        end
      end
      ST_X3_SQ: begin
        alu_use = 1'b1; alu_req.op = ALU_MUL; alu_req.a = tmp_r; alu_req.b = tmp_r;
        if (alu_cap) begin
          x3_nxt = alu_resp.acc; state_nxt = ST_X3_S1;
        end
      end
      ST_X3_S1: begin
        alu_use = 1'b1; alu_req.op = ALU_SUB; alu_req.a = x3_r; alu_req.b = x1_r;
        if (alu_cap) begin
          x3_nxt = alu_resp.acc; state_nxt = ST_X3_S2;
        end
      end
      ST_X3_S2: begin
        alu_use = 1'b1; alu_req.op = ALU_SUB; alu_req.a = x3_r; alu_req.b = x2_r;
        if (alu_cap) begin
          x3_nxt = alu_resp.acc; state_nxt = ST_Y3_D;
        end
      end
      ST_Y3_D: begin
        alu_use = 1'b1; alu_req.op = ALU_SUB; alu_req.a = x1_r; alu_req.b = x3_r;
        if (alu_cap) begin
          y3_nxt = alu_resp.acc; state_nxt = ST_Y3_M;
        end
      end
      ST_Y3_M: begin
        alu_use = 1'b1; alu_req.op = ALU_MUL; alu_req.a = tmp_r; alu_req.b = y3_r;
        if (alu_cap) begin
          y3_nxt = alu_resp.acc; state_nxt = ST_Y3_S;
        end
      end
      ST_Y3_S: begin
        alu_use = 1'b1; alu_req.op = ALU_SUB; alu_req.a = y3_r; alu_req.b = y1_r;
        if (alu_cap) begin
          y3_nxt = alu_resp.acc; state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    alu_req.start = alu_use && !wait_r;
    if (alu_req.start) begin
      wait_nxt = 1'b1;
    end
    if (alu_cap) begin
      wait_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.sum_x       = inf_r ? '0 : x3_r;
      out_data_nxt.sum_y       = inf_r ? '0 : y3_r;
      out_data_nxt.at_infinity = inf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wait_r      <= 1'b0;
      out_valid_r <= 1'b0;
      prime_r     <= PRIME_RESET;
      curve_a_r   <= CURVE_A_RESET;
    end else begin
      state_r     <= state_nxt;
      wait_r      <= wait_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_PRIME:   prime_r   <= cfg_data;
          REG_CURVE_A: curve_a_r <= cfg_data;
          default:     ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    inf_r      <= inf_nxt;
    out_data_r <= out_data_nxt;
    x1_r  <= x1_nxt;
    y1_r  <= y1_nxt;
    x2_r  <= x2_nxt;
    y2_r  <= y2_nxt;
    a_r   <= a_nxt;
    num_r <= num_nxt;
    tmp_r <= tmp_nxt;
    r1_r  <= r1_nxt;
    r2_r  <= r2_nxt;
    t1_r  <= t1_nxt;
    t2_r  <= t2_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    x3_r  <= x3_nxt;
    y3_r  <= y3_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_alu_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    alu_req.start |-> !alu_resp.busy)
    else $error("shared unit started while busy");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != ST_IDLE))
    else $error("accepted beat did not start an addition");

  a_inf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.at_infinity) |-> (out_data.sum_x == '0 && out_data.sum_y == '0))
    else $error("point at infinity with nonzero coordinates");

  a_sum_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.at_infinity) |->
      (out_data.sum_x < prime_r && out_data.sum_y < prime_r))
    else $error("sum not reduced below the modulus");
`endif

endmodule
